/* rtl/core/midi_trigger_matcher_defines.svh */
// Assertion macros used by the checker file
`ifndef MIDI_TRIGGER_MATCHER_DEFINES_SVH
`define MIDI_TRIGGER_MATCHER_DEFINES_SVH

// Clocked assertion, off while reset is asserted
`define MTM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define MTM_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/mtm_pkg.sv */
// Types, register indexes and MIDI constants for the trigger matcher
package mtm_pkg;

	localparam int TIME_WIDTH_DEF = 32;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 16;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STATUS      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_DATA  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_DATA = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ACTION      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BEND_LOW    = 3'd6;

	// Register reset values
	localparam logic [7:0]  STATUS_RST   = 8'h80;
	localparam logic [15:0] DEBOUNCE_RST = 16'd100;
	localparam logic [6:0]  BEND_LOW_RST = 7'd10;

	// Status high nibbles
	localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
	localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
	localparam logic [3:0] NIB_CTRL     = 4'hB;
	localparam logic [3:0] NIB_PROG     = 4'hC;
	localparam logic [3:0] NIB_BEND     = 4'hE;
	localparam logic [3:0] NIB_SYSTEM   = 4'hF;

	// Controller numbers
	localparam logic [6:0] CC_MOMENTARY_LO = 7'd64;
	localparam logic [6:0] CC_MOMENTARY_HI = 7'd97;
	localparam logic [6:0] CC_BANK_MSB     = 7'd0;
	localparam logic [6:0] CC_BANK_LSB     = 7'd32;

	typedef struct packed {
		logic        enable;
		logic [7:0]  status;
		logic [6:0]  first_data;
		logic [6:0]  second_data;
		logic [2:0]  action;
		logic [15:0] debounce;
		logic [6:0]  bend_low;
	} cfg_t;

	typedef struct packed {
		logic [7:0] status;
		logic [6:0] first_data;
		logic [6:0] second_data;
	} msg_t;

	typedef struct packed {
		logic       fire;
		logic [2:0] action;
	} result_t;

endpackage

/* rtl/core/mtm_cfg.sv */
// Configuration registers and trigger-change detect
module mtm_cfg
	import mtm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg,
	output logic                  trig_change
);

	cfg_t cfg_q;

	// A changed trigger field drops the debounce arm
	always_comb begin
		trig_change = 1'b0;
		if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_ENABLE:      trig_change = cfg_data[0] != cfg_q.enable;
				REG_STATUS:      trig_change = cfg_data[7:0] != cfg_q.status;
				REG_FIRST_DATA:  trig_change = cfg_data[6:0] != cfg_q.first_data;
				REG_SECOND_DATA: trig_change = cfg_data[6:0] != cfg_q.second_data;
				default:         trig_change = 1'b0;
			endcase
		end
	end

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable      <= 1'b0;
			cfg_q.status      <= STATUS_RST;
			cfg_q.first_data  <= '0;
			cfg_q.second_data <= '0;
			cfg_q.action      <= '0;
			cfg_q.debounce    <= DEBOUNCE_RST;
			cfg_q.bend_low    <= BEND_LOW_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_ENABLE:      cfg_q.enable      <= cfg_data[0];
				REG_STATUS:      cfg_q.status      <= cfg_data[7:0];
				REG_FIRST_DATA:  cfg_q.first_data  <= cfg_data[6:0];
				REG_SECOND_DATA: cfg_q.second_data <= cfg_data[6:0];
				REG_ACTION:      cfg_q.action      <= cfg_data[2:0];
				REG_DEBOUNCE:    cfg_q.debounce    <= cfg_data;
				REG_BEND_LOW:    cfg_q.bend_low    <= cfg_data[6:0];
				default:         ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/core/mtm_match.sv */
// Trigger compare, debounce state and fire decision
module mtm_match
	import mtm_pkg::*;
#(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  trig_change,
	input  logic                  advance,
	input  msg_t                  msg,
	input  logic [TIME_WIDTH-1:0] now,
	output result_t               result
);

	logic [TIME_WIDTH-1:0] armed_time_q;
	logic                  active_q;

	logic [3:0]            thi;
	logic [3:0]            mhi;
	logic                  same_note;
	logic                  t_on;
	logic                  t_off;
	logic                  m_off;
	logic [TIME_WIDTH-1:0] elapsed;
	logic                  in_window;
	logic                  fire_c;
	logic                  do_arm;
	logic                  do_disarm;

	// Message classification
	always_comb begin
		thi       = cfg.status[7:4];
		mhi       = msg.status[7:4];
		same_note = (msg.status[3:0] == cfg.status[3:0]) &&
			(msg.first_data == cfg.first_data);
		t_on      = (thi == NIB_NOTE_ON) && (cfg.second_data != '0);
		t_off     = (thi == NIB_NOTE_OFF) ||
			((thi == NIB_NOTE_ON) && (cfg.second_data == '0));
		m_off     = (mhi == NIB_NOTE_OFF) ||
			((mhi == NIB_NOTE_ON) && (msg.second_data == '0));
		elapsed   = now - armed_time_q;
		in_window = active_q &&
			(elapsed < {{(TIME_WIDTH-CFG_DATA_W){1'b0}}, cfg.debounce});
	end

	// Fire decision, first matching rule wins
	always_comb begin
		fire_c    = 1'b0;
		do_arm    = 1'b0;
		do_disarm = 1'b0;
		priority if (!cfg.enable) begin
			fire_c = 1'b0;
		end else if (t_on && m_off && same_note) begin
			do_disarm = 1'b1;
		end else if (t_off && (mhi == NIB_NOTE_ON) && (msg.second_data == '0) &&
				same_note) begin
			do_arm = 1'b1;
			fire_c = 1'b1;
		end else if (msg.status != cfg.status) begin
			fire_c = 1'b0;
		end else if (mhi == NIB_SYSTEM) begin
			fire_c = 1'b1;
		end else if (mhi == NIB_PROG) begin
			fire_c = msg.first_data == cfg.first_data;
		end else if (mhi == NIB_BEND) begin
			if ((msg.second_data == '0) && (msg.first_data < cfg.bend_low)) begin
				do_disarm = 1'b1;
			end else if (!in_window) begin
				do_arm = 1'b1;
				fire_c = 1'b1;
			end
		end else if ((mhi == NIB_CTRL) && (msg.first_data >= CC_MOMENTARY_LO) &&
				(msg.first_data <= CC_MOMENTARY_HI)) begin
			fire_c = msg.second_data != '0;
		end else if ((mhi == NIB_CTRL) && ((msg.first_data == CC_BANK_MSB) ||
				(msg.first_data == CC_BANK_LSB))) begin
			fire_c = msg.second_data == cfg.second_data;
		end else if (((mhi == NIB_NOTE_OFF) || (mhi == NIB_NOTE_ON)) &&
				(msg.first_data != cfg.first_data)) begin
			fire_c = 1'b0;
		end else if (msg.second_data == '0) begin
			do_disarm = 1'b1;
		end else if (!in_window) begin
			do_arm = 1'b1;
			fire_c = 1'b1;
		end else begin
			// repeat inside the debounce window is dropped
			fire_c = 1'b0;
		end
	end

	// Debounce state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_time_q <= '0;
			active_q     <= 1'b0;
		end else if (trig_change) begin
			active_q <= 1'b0;
		end else if (advance) begin
			if (do_arm) begin
				armed_time_q <= now;
				active_q     <= 1'b1;
			end else if (do_disarm) begin
				active_q <= 1'b0;
			end
		end
	end

	assign result.fire   = fire_c;
	assign result.action = fire_c ? cfg.action : 3'd0;

endmodule

/* rtl/core/midi_trigger_matcher.sv */
// MIDI trigger matcher: one message beat in, one fire/action beat out. A message is
// captured in an input register, compared against the trigger combinationally and
// the decision is written to an output register, and one message is taken every
// cycle while the output side keeps up. The debounce arm time is updated in the
// same cycle the decision is made, so back-to-back messages see each other's
// effect. Configuration writes take effect on the next cycle.
module midi_trigger_matcher
	import mtm_pkg::*;
#(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            status_byte,
	input  logic [6:0]            first_data,
	input  logic [6:0]            second_data,
	input  logic [TIME_WIDTH-1:0] now_ms,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  fire,
	output logic [2:0]            fired_action
);

	cfg_t                  cfg;
	logic                  trig_change;
	logic                  valid_s1;
	msg_t                  msg_s1;
	logic [TIME_WIDTH-1:0] now_s1;
	logic                  valid_s2;
	result_t               result_s2;
	result_t               result_c;
	logic                  advance;

	// Stage 1 moves on when the output register is free or draining
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	mtm_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cfg         (cfg),
		.trig_change (trig_change)
	);

	mtm_match #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_match (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.trig_change (trig_change),
		.advance     (advance),
		.msg         (msg_s1),
		.now         (now_s1),
		.result      (result_c)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			msg_s1.status      <= status_byte;
			msg_s1.first_data  <= first_data;
			msg_s1.second_data <= second_data;
			now_s1             <= now_ms;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_c;
		end
	end

	assign out_valid    = valid_s2;
	assign fire         = result_s2.fire;
	assign fired_action = result_s2.action;

endmodule

/* rtl/core/mtm_checker.sv */
// Port-level checks for the trigger matcher, bound to the top level
`include "midi_trigger_matcher_defines.svh"

module mtm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       fire,
	input logic [2:0] fired_action
);

	// A stalled result beat holds
	`MTM_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(fire) && $stable(fired_action), "result beat changed while stalled")

	// No action code without a fire
	`MTM_ASSERT(a_action_zero, out_valid && !fire |-> fired_action == 3'd0, "action reported without fire")

	// Input only stalls behind a blocked output
	`MTM_ASSERT(a_ready_stall, !in_ready |-> out_valid && !out_ready, "input stalled with free output")

	// No result during reset
	`MTM_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !out_valid, "result valid in reset")

endmodule

bind midi_trigger_matcher mtm_checker u_mtm_checker (.*);

/* sim/testbench.sv */
// Self-checking testbench for the MIDI trigger matcher: directed table, then random phases
module testbench;
	import mtm_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;	// unmapped index, must be ignored
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 50;
	localparam int STALL_LIMIT = 1000;

	typedef enum int {
		TRIG_SYSTEM, TRIG_PROG, TRIG_MOMENTARY, TRIG_BANK, TRIG_OTHER_CC,
		TRIG_BEND, TRIG_NOTE_ON, TRIG_NOTE_OFF, TRIG_NOTE_ZERO
	} trig_kind_e;

	// one row of the directed script: a register write or a message beat
	typedef struct {
		bit                    is_wr;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] wdata;
		msg_t                  msg;
		logic [31:0]           at_ms;
		bit                    typed;
		result_t               want;
	} script_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [7:0]            status_byte;
	logic [6:0]            first_data;
	logic [6:0]            second_data;
	logic [31:0]           now_ms;
	logic                  out_valid;
	logic                  out_ready;
	logic                  fire;
	logic [2:0]            fired_action;

	// shadow of the trigger registers and debounce state
	cfg_t        trig_cfg;
	logic [31:0] armed_ms;
	logic        armed;

	result_t     expected_q[$];
	script_row_t script[$];
	int          mismatches = 0;
	bit          calm = 1'b0;
	result_t     head;

	midi_trigger_matcher #(.TIME_WIDTH(32)) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.status_byte (status_byte),
		.first_data  (first_data),
		.second_data (second_data),
		.now_ms      (now_ms),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.fire        (fire),
		.fired_action(fired_action)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// decision for one message; updates the debounce shadow
	function automatic result_t match_message(msg_t m, logic [31:0] t);
		logic [3:0]  thi;
		logic [3:0]  mhi;
		logic        same_note;
		logic        t_on;
		logic        t_off;
		logic        m_off;
		logic        soon;
		logic        hit;
		logic [31:0] gap;
		result_t     r;
		thi = trig_cfg.status[7:4];
		mhi = m.status[7:4];
		same_note = (m.status[3:0] == trig_cfg.status[3:0]) &&
			(m.first_data == trig_cfg.first_data);
		t_on  = (thi == NIB_NOTE_ON) && (trig_cfg.second_data != 7'd0);
		t_off = (thi == NIB_NOTE_OFF) || ((thi == NIB_NOTE_ON) && (trig_cfg.second_data == 7'd0));
		m_off = (mhi == NIB_NOTE_OFF) || ((mhi == NIB_NOTE_ON) && (m.second_data == 7'd0));
		gap  = t - armed_ms;
		soon = armed && (gap < {16'd0, trig_cfg.debounce});
		hit  = 1'b0;
		if (trig_cfg.enable) begin
			if (t_on && m_off && same_note) begin
				armed = 1'b0;
			end else if (t_off && mhi == NIB_NOTE_ON && m.second_data == 7'd0 && same_note) begin
				armed_ms = t;
				armed = 1'b1;
				hit = 1'b1;
			end else if (m.status != trig_cfg.status) begin
				// status differs: nothing
			end else if (mhi == NIB_SYSTEM) begin
				hit = 1'b1;
			end else if (mhi == NIB_PROG) begin
				hit = (m.first_data == trig_cfg.first_data);
			end else if (mhi == NIB_BEND) begin
				if (m.second_data == 7'd0 && m.first_data < trig_cfg.bend_low) begin
					armed = 1'b0;
				end else if (!soon) begin
					armed_ms = t;
					armed = 1'b1;
					hit = 1'b1;
				end
			end else if (mhi == NIB_CTRL && m.first_data >= CC_MOMENTARY_LO &&
				m.first_data <= CC_MOMENTARY_HI) begin
				hit = (m.second_data != 7'd0);
			end else if (mhi == NIB_CTRL &&
				(m.first_data == CC_BANK_MSB || m.first_data == CC_BANK_LSB)) begin
				hit = (m.second_data == trig_cfg.second_data);
			end else if ((mhi == NIB_NOTE_OFF || mhi == NIB_NOTE_ON) &&
				m.first_data != trig_cfg.first_data) begin
				// other note: nothing
			end else if (m.second_data == 7'd0) begin
				armed = 1'b0;
			end else if (!soon) begin
				armed_ms = t;
				armed = 1'b1;
				hit = 1'b1;
			end
		end
		r.fire = hit;
		r.action = hit ? trig_cfg.action : 3'd0;
		return r;
	endfunction

	// register write into the shadow; a changed trigger field drops the arm
	function automatic void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		case (idx)
			REG_ENABLE: begin
				if (trig_cfg.enable != d[0]) begin
					trig_cfg.enable = d[0];
					armed = 1'b0;
				end
			end
			REG_STATUS: begin
				if (trig_cfg.status != d[7:0]) begin
					trig_cfg.status = d[7:0];
					armed = 1'b0;
				end
			end
			REG_FIRST_DATA: begin
				if (trig_cfg.first_data != d[6:0]) begin
					trig_cfg.first_data = d[6:0];
					armed = 1'b0;
				end
			end
			REG_SECOND_DATA: begin
				if (trig_cfg.second_data != d[6:0]) begin
					trig_cfg.second_data = d[6:0];
					armed = 1'b0;
				end
			end
			REG_ACTION:   trig_cfg.action = d[2:0];
			REG_DEBOUNCE: trig_cfg.debounce = d;
			REG_BEND_LOW: trig_cfg.bend_low = d[6:0];
			default: ;
		endcase
	endfunction

	// mostly messages aimed at the trigger, the rest noise
	function automatic msg_t pick_message();
		msg_t m;
		int   roll;
		roll = $urandom_range(0, 99);
		m.status      = {1'b1, 7'($urandom)};
		m.first_data  = 7'($urandom);
		m.second_data = 7'($urandom);
		if (roll < 60) begin
			m.status = trig_cfg.status;
			if ($urandom_range(0, 3) != 0)
				m.first_data = trig_cfg.first_data;
		end else if (roll < 75) begin
			// paired note message on the trigger channel
			m.status = {($urandom_range(0, 1) ? NIB_NOTE_OFF : NIB_NOTE_ON), trig_cfg.status[3:0]};
			if ($urandom_range(0, 3) != 0)
				m.first_data = trig_cfg.first_data;
		end
		if (roll < 75) begin
			case ($urandom_range(0, 5))
				0, 1: m.second_data = 7'd0;
				2: m.second_data = trig_cfg.second_data;
				default: ;
			endcase
		end
		return m;
	endfunction

	task automatic put_wr(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		script_row_t row;
		row = '{default: '0};
		row.is_wr = 1'b1;
		row.idx = idx;
		row.wdata = d;
		script.push_back(row);
	endtask

	task automatic put_msg(logic [7:0] st, logic [6:0] d1, logic [6:0] d2, logic [31:0] t,
		bit typed = 1'b0, logic f = 1'b0, logic [2:0] act = 3'd0);
		script_row_t row;
		row = '{default: '0};
		row.msg = '{status: st, first_data: d1, second_data: d2};
		row.at_ms = t;
		row.typed = typed;
		row.want = '{fire: f, action: act};
		script.push_back(row);
	endtask

	task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		apply_write(idx, d);
	endtask

	// one message beat; expectation is queued at the accepting edge
	task automatic send_item(msg_t m, logic [31:0] t, bit typed, result_t want);
		result_t r;
		in_valid    <= 1'b1;
		status_byte <= m.status;
		first_data  <= m.first_data;
		second_data <= m.second_data;
		now_ms      <= t;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		r = match_message(m, t);
		expected_q.push_back(typed ? want : r);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	// let the pipe empty before touching registers
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// result side: random stall bursts, always a ready cycle between bursts
	initial begin : sink_pacing
		int hold;
		hold = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold != 0) begin
				out_ready <= 1'b0;
				hold--;
			end else if (!calm && out_ready && $urandom_range(0, 9) == 0) begin
				out_ready <= 1'b0;
				hold = $urandom_range(1, 18) - 1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result beat: expected none, actual fire=%0b action=%0d",
					$time, fire, fired_action);
				mismatches++;
			end else begin
				head = expected_q.pop_front();
				if (fire !== head.fire) begin
					$display("%0t: fire expected %0b actual %0b", $time, head.fire, fire);
					mismatches++;
				end
				if (fired_action !== head.action) begin
					$display("%0t: fired_action expected %0d actual %0d",
						$time, head.action, fired_action);
					mismatches++;
				end
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : stimulus
		bit                    wr_open;
		int                    p;
		int                    i;
		int                    chan;
		trig_kind_e            kind;
		logic [7:0]            nst;
		logic [6:0]            nfirst;
		logic [6:0]            nsecond;
		logic [CFG_DATA_W-1:0] deb;
		logic [6:0]            bend;
		logic [2:0]            act;
		logic                  en;
		logic [31:0]           clock_ms;
		msg_t                  m;

		arst_n      <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_index   <= REG_ENABLE;
		cfg_data    <= '0;
		in_valid    <= 1'b0;
		status_byte <= STATUS_RST;
		first_data  <= 7'd0;
		second_data <= 7'd0;
		now_ms      <= 32'd0;
		trig_cfg = '{enable: 1'b0, status: STATUS_RST, first_data: 7'd0, second_data: 7'd0,
			action: 3'd0, debounce: DEBOUNCE_RST, bend_low: BEND_LOW_RST};
		armed_ms = 32'd0;
		armed = 1'b0;

		// directed script
		put_msg(8'h90, 7'd0, 7'd0, 32'd0, 1'b1, 1'b0, 3'd0);	// disabled after reset
		put_msg(8'hFF, 7'd127, 7'd127, 32'hFFFF_FFFF, 1'b1, 1'b0, 3'd0);
		put_wr(REG_ACTION, 16'd5);
		put_wr(REG_ENABLE, 16'd1);
		// reset trigger is a note-off on note 0: zero-velocity note-on fires
		put_msg(8'h90, 7'd0, 7'd0, 32'd5, 1'b1, 1'b1, 3'd5);
		put_msg(8'h80, 7'd0, 7'd64, 32'd6);
		put_wr(REG_STATUS, 16'hFFF8);	// upper data bits ignored
		put_wr(REG_ACTION, 16'hFFFF);
		put_msg(8'hF8, 7'd127, 7'd127, 32'd10, 1'b1, 1'b1, 3'd7);
		put_msg(8'hFE, 7'd0, 7'd0, 32'd11);
		put_wr(REG_STATUS, 16'h00C3);
		put_wr(REG_FIRST_DATA, 16'd42);
		put_msg(8'hC3, 7'd42, 7'd0, 32'd12, 1'b1, 1'b1, 3'd7);
		put_msg(8'hC3, 7'd41, 7'd0, 32'd13);
		put_msg(8'hC4, 7'd42, 7'd0, 32'd14);
		put_wr(REG_STATUS, 16'h00B0);
		put_wr(REG_FIRST_DATA, 16'd64);
		put_msg(8'hB0, 7'd64, 7'd127, 32'd15, 1'b1, 1'b1, 3'd7);
		put_msg(8'hB0, 7'd64, 7'd0, 32'd16);
		put_msg(8'hB0, 7'd97, 7'd1, 32'd17);
		put_msg(8'hB0, 7'd98, 7'd5, 32'd20);	// ordinary controller, debounced
		put_wr(REG_STATUS, 16'h00B1);
		put_wr(REG_SECOND_DATA, 16'd127);
		put_msg(8'hB1, 7'd0, 7'd127, 32'd21, 1'b1, 1'b1, 3'd7);
		put_msg(8'hB1, 7'd32, 7'd5, 32'd22);
		// pitch bend with widest window and highest release limit
		put_wr(REG_STATUS, 16'h00EF);
		put_wr(REG_DEBOUNCE, 16'hFFFF);
		put_wr(REG_BEND_LOW, 16'd127);
		put_wr(REG_ACTION, 16'd2);
		put_msg(8'hEF, 7'd5, 7'd100, 32'd1000);
		put_msg(8'hEF, 7'd5, 7'd100, 32'd2000);
		put_msg(8'hEF, 7'd126, 7'd0, 32'd2001);
		put_msg(8'hEF, 7'd0, 7'd0, 32'd2001);
		put_msg(8'hEF, 7'd127, 7'd0, 32'd2002);
		put_msg(8'hEF, 7'd127, 7'd0, 32'hFFFF_FFFF);
		put_msg(8'hEF, 7'd64, 7'd64, 32'd16);	// inside window across the wrap
		// note-on trigger, no debounce window
		put_wr(REG_STATUS, 16'h0095);
		put_wr(REG_FIRST_DATA, 16'd60);
		put_wr(REG_SECOND_DATA, 16'd100);
		put_wr(REG_DEBOUNCE, 16'd0);
		put_wr(REG_BEND_LOW, 16'd0);
		put_msg(8'h95, 7'd60, 7'd1, 32'd3000);
		put_msg(8'h95, 7'd60, 7'd1, 32'd3000);
		put_msg(8'h85, 7'd60, 7'd0, 32'd3001);
		put_msg(8'h95, 7'd61, 7'd100, 32'd3002);
		put_msg(8'h95, 7'd60, 7'd0, 32'd3003);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// walk the directed script
		wr_open = 1'b0;
		foreach (script[k]) begin
			if (script[k].is_wr) begin
				if (!wr_open)
					settle();
				wr_open = 1'b1;
				reg_write(script[k].idx, script[k].wdata);
			end else begin
				if (wr_open)
					cfg_wr_en <= 1'b0;
				wr_open = 1'b0;
				send_item(script[k].msg, script[k].at_ms, script[k].typed, script[k].want);
			end
		end

		// random phases, each with fresh register settings; some keep the trigger
		clock_ms = $urandom;
		for (p = 0; p < PHASES; p++) begin
			settle();
			calm = (p == PHASES - 1);
			kind = trig_kind_e'($urandom_range(0, 8));
			chan = $urandom_range(0, 15);
			nfirst = 7'($urandom);
			nsecond = 7'($urandom);
			case (kind)
				TRIG_SYSTEM:    nst = {NIB_SYSTEM, 4'(chan)};
				TRIG_PROG:      nst = {NIB_PROG, 4'(chan)};
				TRIG_MOMENTARY: begin
					nst = {NIB_CTRL, 4'(chan)};
					nfirst = 7'($urandom_range(CC_MOMENTARY_LO, CC_MOMENTARY_HI));
				end
				TRIG_BANK: begin
					nst = {NIB_CTRL, 4'(chan)};
					nfirst = $urandom_range(0, 1) ? CC_BANK_LSB : CC_BANK_MSB;
				end
				TRIG_OTHER_CC: begin
					nst = {NIB_CTRL, 4'(chan)};
					nfirst = $urandom_range(0, 1) ? 7'($urandom_range(1, 31)) :
						7'($urandom_range(98, 127));
				end
				TRIG_BEND:      nst = {NIB_BEND, 4'(chan)};
				TRIG_NOTE_ON: begin
					nst = {NIB_NOTE_ON, 4'(chan)};
					nsecond = 7'($urandom_range(1, 127));
				end
				TRIG_NOTE_OFF:  nst = {NIB_NOTE_OFF, 4'(chan)};
				default: begin
					nst = {NIB_NOTE_ON, 4'(chan)};
					nsecond = 7'd0;
				end
			endcase
			case ($urandom_range(0, 3))
				0: deb = 16'd0;
				1: deb = 16'($urandom_range(1, 300));
				2: deb = 16'($urandom);
				default: deb = 16'hFFFF;
			endcase
			bend = 7'($urandom);
			act = 3'($urandom);
			en = (p == 5) ? 1'b0 : 1'b1;
			// floor and ceiling settings first
			if (p == 0) begin
				nst = 8'h80; nfirst = 7'd0; nsecond = 7'd0;
				act = 3'd0; deb = 16'd0; bend = 7'd0;
			end else if (p == 1) begin
				nst = 8'hFF; nfirst = 7'd127; nsecond = 7'd127;
				act = 3'd7; deb = 16'hFFFF; bend = 7'd127;
			end
			// some phases keep the trigger so the arm carries over
			if (p % 4 != 3) begin
				reg_write(REG_ENABLE, {15'($urandom), en});
				reg_write(REG_STATUS, {8'($urandom), nst});
				reg_write(REG_FIRST_DATA, {9'($urandom), nfirst});
				reg_write(REG_SECOND_DATA, {9'($urandom), nsecond});
			end
			reg_write(REG_ACTION, {13'($urandom), act});
			reg_write(REG_DEBOUNCE, deb);
			reg_write(REG_BEND_LOW, {9'($urandom), bend});
			if ($urandom_range(0, 2) == 0)
				reg_write(REG_NONE, 16'($urandom));
			cfg_wr_en <= 1'b0;
			for (i = 0; i < PHASE_ITEMS; i++) begin
				m = pick_message();
				// steps around the window length, rare jumps anywhere
				if ($urandom_range(0, 39) == 0)
					clock_ms = $urandom;
				else
					clock_ms = clock_ms + 32'($urandom_range(0, 2 * int'(trig_cfg.debounce) + 4));
				send_item(m, clock_ms, 1'b0, '0);
			end
		end

		settle();
		repeat (4) @(posedge clk);
		if (mismatches == 0 && expected_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
